FILE: sv/dlq_pkg.sv
// shared constants and types for the deadline event queue
`default_nettype none
package dlq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam logic [15:0] DEFAULT_WAIT_RST = 16'd2000;

  localparam logic        OP_SCHED   = 1'b0;
  localparam logic        OP_POLL    = 1'b1;

  localparam logic [1:0]  KIND_SCHED = 2'd0;
  localparam logic [1:0]  KIND_FIRED = 2'd1;
  localparam logic [1:0]  KIND_PAUSE = 2'd2;
  localparam logic [1:0]  KIND_NONE  = 2'd3;

  localparam int unsigned ENTRY_W    = 40;

  // one queue slot
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  event_id;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         fired_id;
    logic signed [32:0] wait_ms;
    logic               rejected;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/dlq_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module dlq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/dlq_ctrl.sv
// sequencer: sorted insert and ordered drain over the queue memory
`default_nettype none
module dlq_ctrl
  import dlq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [23:0] fire_delay,
  input  wire logic [7:0]  event_id,
  input  wire logic [15:0] default_wait,
  input  wire logic        out_free,
  output logic             push,
  output result_t          res
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SH_RD    = 3'd1;
  localparam logic [2:0] ST_SH_CMP   = 3'd2;
  localparam logic [2:0] ST_SC_ANS   = 3'd3;
  localparam logic [2:0] ST_PL_RD    = 3'd4;
  localparam logic [2:0] ST_PL_CMP   = 3'd5;
  localparam logic [2:0] ST_PL_PAUSE = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] pos, pos_next;
  logic [31:0]   front_dl, front_dl_next;
  logic [15:0]   pause, pause_next;
  logic          rej, rej_next;
  logic [31:0]   now_r, dl_r;
  logic [7:0]    id_r;

  logic          rd_en, wr_en;
  logic [CW-1:0] rd_off, wr_off;
  entry_t        wr_data, rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [32:0]   sat_sum;
  logic [31:0]   gap;

  // logical slot to physical address, circular from head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign sat_sum  = {1'b0, now_ms} + {9'b0, fire_delay};
  assign gap      = rd_data.deadline - now_r;
  assign rd_addr  = phys(head, rd_off);
  assign wr_addr  = phys(head, wr_off);

  dlq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next    = state;
    count_next    = count;
    head_next     = head;
    pos_next      = pos;
    front_dl_next = front_dl;
    pause_next    = pause;
    rej_next      = rej;
    rd_en         = 1'b0;
    rd_off        = '0;
    wr_en         = 1'b0;
    wr_off        = '0;
    wr_data       = rd_data;
    push          = 1'b0;
    res           = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_SCHED) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              rej_next   = 1'b1;
              state_next = ST_SC_ANS;
            end else begin
              rej_next   = 1'b0;
              pos_next   = count;
              state_next = ST_SH_RD;
            end
          end else begin
            state_next = ST_PL_RD;
          end
        end
      end
      ST_SH_RD: begin
        if (pos == '0) begin
          wr_en         = 1'b1;
          wr_data       = '{deadline: dl_r, event_id: id_r};
          front_dl_next = dl_r;
          count_next    = count + CW'(1);
          state_next    = ST_SC_ANS;
        end else begin
          rd_en      = 1'b1;
          rd_off     = pos - CW'(1);
          state_next = ST_SH_CMP;
        end
      end
      ST_SH_CMP: begin
        wr_en  = 1'b1;
        wr_off = pos;
        if (rd_data.deadline > dl_r) begin
          // move the later entry up one slot
          wr_data    = rd_data;
          pos_next   = pos - CW'(1);
          state_next = ST_SH_RD;
        end else begin
          wr_data    = '{deadline: dl_r, event_id: id_r};
          count_next = count + CW'(1);
          state_next = ST_SC_ANS;
        end
      end
      ST_SC_ANS: begin
        if (out_free) begin
          push         = 1'b1;
          res.kind     = KIND_SCHED;
          res.wait_ms  = {1'b0, front_dl} - {1'b0, now_r};
          res.rejected = rej;
          res.last     = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_PL_RD: begin
        if (count == '0) begin
          pause_next = default_wait;
          state_next = ST_PL_PAUSE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_PL_CMP;
        end
      end
      ST_PL_CMP: begin
        if (rd_data.deadline <= now_r) begin
          if (out_free) begin
            push         = 1'b1;
            res.kind     = KIND_FIRED;
            res.fired_id = rd_data.event_id;
            head_next    = phys(head, CW'(1));
            count_next   = count - CW'(1);
            state_next   = ST_PL_RD;
          end
        end else begin
          front_dl_next = rd_data.deadline;
          pause_next    = (gap < {16'b0, default_wait}) ? gap[15:0] : default_wait;
          state_next    = ST_PL_PAUSE;
        end
      end
      ST_PL_PAUSE: begin
        if (out_free) begin
          push        = 1'b1;
          res.kind    = KIND_PAUSE;
          res.wait_ms = {17'b0, pause};
          res.last    = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      head  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    front_dl <= front_dl_next;
    pause    <= pause_next;
    rej      <= rej_next;
    if (in_valid && in_ready) begin
      now_r <= now_ms;
      dl_r  <= sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
      id_r  <= event_id;
    end
  end

endmodule
`default_nettype wire

FILE: sv/deadline_event_queue.sv
// top level of the deadline event queue
//
//  channel  | direction | tdata (low bit up)                       | tuser     | tlast
//  s_axis   | in        | now_ms[31:0] fire_delay[55:32] id[63:56]  | operation | -
//  m_axis   | out       | fired_id[7:0] wait_ms[40:8] rejected[41]  | kind      | last
//  cfg      | in        | default_wait, written when cfg_we is high
//
// one transaction is worked on at a time; s_tready is high only while idle
// schedule: each pending entry with a later deadline is read and moved up one slot, and
//   then the new entry is written and answered; a full queue goes straight to its rejected answer
// poll: each due front entry is read and fired, then a pause answer ends the transaction
// the result register lets the next input transaction in while a result waits
// a stalled m_tready holds the sequencer in place; no result is dropped
// rst clears the queue count, head pointer and result valid, and sets default_wait to its reset value
`default_nettype none
module deadline_event_queue
  import dlq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // now_ms, fire_delay, event_id
  input  wire logic        s_tuser,   // operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // fired_id, wait_ms, rejected, zero pad
  output logic      [1:0]  m_tuser,   // kind
  output logic             m_tlast,   // last
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata  // default_wait
);

  logic [15:0] default_wait;
  logic        out_free;
  logic        push;
  result_t     res;
  result_t     out_r;

  // result register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_wait <= DEFAULT_WAIT_RST;
    end else if (cfg_we) begin
      default_wait <= cfg_wdata;
    end
  end

  dlq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .operation    (s_tuser),
    .now_ms       (s_tdata[31:0]),
    .fire_delay   (s_tdata[55:32]),
    .event_id     (s_tdata[63:56]),
    .default_wait (default_wait),
    .out_free     (out_free),
    .push         (push),
    .res          (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_r <= res;
    end
  end

  assign m_tdata = {6'b0, out_r.rejected, out_r.wait_ms, out_r.fired_id};
  assign m_tuser = out_r.kind;
  assign m_tlast = out_r.last;

endmodule
`default_nettype wire

FILE: sv/dlq_checker.sv
// port-level checks for the deadline event queue, bound to the top level
`default_nettype none
module dlq_checker
  import dlq_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one input transaction at a time
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // only a fired event is not the last result of its transaction
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_FIRED) != m_tlast))
    else $error("last flag does not match kind");

  // rejection only on a schedule answer
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[41] |-> m_tuser == KIND_SCHED)
    else $error("rejected flag outside schedule answer");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != KIND_NONE)
    else $error("undefined result kind");

endmodule

bind deadline_event_queue dlq_checker u_dlq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

FILE: sim/dlq_result_check.sv
`timescale 1ns / 1ps
// result checker for the deadline event queue: shadow queue and in-order compare
module dlq_result_check
  import dlq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tuser,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [47:0] m_tdata,
  input  wire logic [1:0]  m_tuser,
  input  wire logic        m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output int unsigned      error_count,
  output int unsigned      results_waiting,
  output int unsigned      results_checked,
  output int unsigned      events_fired,
  output int unsigned      schedules_rejected
);

  // shadow copy of the queue, kept in deadline order
  logic [31:0] shadow_deadline [QUEUE_DEPTH_DEF];
  logic [7:0]  shadow_event    [QUEUE_DEPTH_DEF];
  int unsigned shadow_count;
  logic [15:0] shadow_cap;
  result_t     awaited_results [$];

  function automatic logic [32:0] time_gap(input logic [31:0] later, input logic [31:0] earlier);
    return {1'b0, later} - {1'b0, earlier};
  endfunction

  function automatic result_t make_result(input logic [1:0] kind, input logic [7:0] id,
                                          input logic [32:0] gap, input logic rej,
                                          input logic fin);
    result_t r;
    r.kind     = kind;
    r.fired_id = id;
    r.wait_ms  = gap;
    r.rejected = rej;
    r.last     = fin;
    return r;
  endfunction

  // append one predicted result at the tail
  task automatic queue_result(input result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endtask

  task automatic predict_results(input logic op, input logic [31:0] now,
                                 input logic [23:0] delay, input logic [7:0] id);
    logic [32:0] sum;
    logic [31:0] due;
    logic [31:0] pause;
    int unsigned slot;
    int unsigned fired;
    if (op == OP_SCHED) begin
      if (shadow_count >= QUEUE_DEPTH_DEF) begin
        // full: nothing stored, flagged answer
        queue_result(make_result(KIND_SCHED, 8'd0,
                                 time_gap(shadow_deadline[0], now), 1'b1, 1'b1));
      end else begin
        sum = {1'b0, now} + {9'd0, delay};
        due = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        slot = shadow_count;
        // equal deadlines stay behind older ones
        while (slot > 0 && shadow_deadline[slot-1] > due) begin
          shadow_deadline[slot] = shadow_deadline[slot-1];
          shadow_event[slot]    = shadow_event[slot-1];
          slot--;
        end
        shadow_deadline[slot] = due;
        shadow_event[slot]    = id;
        shadow_count++;
        queue_result(make_result(KIND_SCHED, 8'd0,
                                 time_gap(shadow_deadline[0], now), 1'b0, 1'b1));
      end
    end else begin
      fired = 0;
      while (fired < shadow_count && shadow_deadline[fired] <= now) begin
        queue_result(make_result(KIND_FIRED, shadow_event[fired], '0, 1'b0, 1'b0));
        fired++;
      end
      for (int unsigned i = fired; i < shadow_count; i++) begin
        shadow_deadline[i-fired] = shadow_deadline[i];
        shadow_event[i-fired]    = shadow_event[i];
      end
      shadow_count -= fired;
      pause = {16'd0, shadow_cap};
      if (shadow_count > 0 && shadow_deadline[0] - now < pause)
        pause = shadow_deadline[0] - now;
      queue_result(make_result(KIND_PAUSE, 8'd0, {1'b0, pause}, 1'b0, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      error_count++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      error_count++;
      $error("unexpected result transaction, kind %0d", m_tuser);
    end else begin
      want = awaited_results.pop_front();
      results_checked++;
      check_field("kind", want.kind, m_tuser);
      check_field("fired_id", want.fired_id, m_tdata[7:0]);
      check_field("wait_ms", want.wait_ms, $signed(m_tdata[40:8]));
      check_field("rejected", want.rejected, m_tdata[41]);
      check_field("last", want.last, m_tlast);
      if (want.kind == KIND_FIRED) events_fired++;
      if (want.rejected) schedules_rejected++;
    end
  endtask

  // results leave before the new input is predicted; both are in order anyway
  always @(posedge clk) begin
    if (rst) begin
      awaited_results.delete();
      shadow_count = 0;
      shadow_cap   = DEFAULT_WAIT_RST;
    end else begin
      if (m_tvalid && m_tready) compare_result();
      if (cfg_we) shadow_cap = cfg_wdata;
      if (s_tvalid && s_tready)
        predict_results(s_tuser, s_tdata[31:0], s_tdata[55:32], s_tdata[63:56]);
    end
    results_waiting = awaited_results.size();
  end

endmodule

FILE: sim/tb_deadline_event_queue.sv
`timescale 1ns / 1ps
// testbench top for the deadline event queue: stimulus, back-pressure and verdict
module tb_deadline_event_queue;
  import dlq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 60;   // beyond a full 16-event poll
  localparam int unsigned PHASE_ITEMS   = 30;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata   = '0;       // now_ms, fire_delay, event_id
  logic        s_tuser   = OP_SCHED; // operation
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [47:0] m_tdata;              // fired_id, wait_ms, rejected, zero pad
  logic [1:0]  m_tuser;              // kind
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;       // default_wait

  int unsigned error_count;
  int unsigned results_waiting;
  int unsigned results_checked;
  int unsigned events_fired;
  int unsigned schedules_rejected;

  // knobs for the current phase, in percent
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  // hold-off requests from the stimulus, served by the receiver process
  int unsigned hold_asked  = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  int unsigned items_sent   = 0;
  int unsigned cap_settings = 0;
  int unsigned cycle_count  = 0;
  logic [31:0] clock_ms;            // running time base for well-formed sequences

  int unsigned phase_idle  [4] = '{0, 67, 0, 23};
  int unsigned phase_stall [4] = '{0, 0, 67, 23};
  logic [15:0] phase_cap   [4] = '{16'hFFFF, 16'd1, 16'd0, 16'd0};

  always #5 clk = ~clk;

  deadline_event_queue dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  dlq_result_check result_check (
    .clk                (clk),
    .rst                (rst),
    .s_tvalid           (s_tvalid),
    .s_tready           (s_tready),
    .s_tdata            (s_tdata),
    .s_tuser            (s_tuser),
    .m_tvalid           (m_tvalid),
    .m_tready           (m_tready),
    .m_tdata            (m_tdata),
    .m_tuser            (m_tuser),
    .m_tlast            (m_tlast),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .error_count        (error_count),
    .results_waiting    (results_waiting),
    .results_checked    (results_checked),
    .events_fired       (events_fired),
    .schedules_rejected (schedules_rejected)
  );

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_asked != hold_served) begin
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
      m_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one input transaction; entered and left just after a falling edge
  // valid is left high so back-to-back transactions need no extra edge
  task automatic send_item(input logic op, input logic [31:0] now,
                           input logic [23:0] delay, input logic [7:0] id);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {id, delay, now};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // wait until every predicted result is back, then let the block settle
  task automatic wait_drained();
    while (results_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // default_wait only changes while the queue is quiet
  task automatic write_cap(input logic [15:0] value);
    s_tvalid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    cap_settings++;
  endtask

  // anything at all: full-range time, delay and id, either operation
  task automatic send_noise();
    logic [31:0] now;
    logic [31:0] bits;
    logic        op;
    now  = $urandom;
    bits = $urandom;
    op   = 1'($urandom_range(1));
    send_item(op, now, bits[23:0], bits[31:24]);
  endtask

  // a run of schedules near the time base, then polls as time moves on
  task automatic run_burst(input int unsigned n_sched, input bit with_noise);
    logic [31:0] bits;
    logic [23:0] delay;
    int unsigned n_poll;
    for (int unsigned i = 0; i < n_sched; i++) begin
      if (with_noise && $urandom_range(7) == 0) begin
        send_noise();
      end else begin
        clock_ms += ($urandom_range(3) == 0) ? 0 : $urandom_range(3);
        bits = $urandom;
        case ($urandom_range(7))
          0:       delay = 24'd100;   // shared delay, so deadlines tie
          1:       delay = bits[23:0];
          default: delay = 24'($urandom_range(400));
        endcase
        send_item(OP_SCHED, clock_ms, delay, bits[31:24]);
      end
    end
    n_poll = $urandom_range(4, 1);
    repeat (n_poll) begin
      clock_ms += $urandom_range(250);
      bits = $urandom;
      send_item(OP_POLL, clock_ms, bits[23:0], bits[31:24]);
    end
    // now at the top of the range: everything pending is due
    if ($urandom_range(3) == 0) send_item(OP_POLL, 32'hFFFF_FFFF, 24'd0, 8'd0);
  endtask

  initial begin
    int unsigned phase_start;
    logic [15:0] cap;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part, reset value of default_wait still in force
    send_item(OP_POLL,  32'd0,           24'd0,       8'd0);  // empty queue, full pause
    send_item(OP_SCHED, 32'hFFFF_FFFF,   24'hFF_FFFF, 8'hFF); // deadline saturates
    send_item(OP_SCHED, 32'd0,           24'd0,       8'd0);
    send_item(OP_POLL,  32'd100,         24'hFF_FFFF, 8'hFF); // fires the zero deadline
    send_item(OP_POLL,  32'hFFFF_FFFF,   24'd0,       8'd0);  // fires the saturated one
    // equal deadlines fire in scheduling order, earlier one jumps ahead
    send_item(OP_SCHED, 32'd1000,        24'd50,      8'd1);
    send_item(OP_SCHED, 32'd1000,        24'd50,      8'd2);
    send_item(OP_SCHED, 32'd1000,        24'd50,      8'd3);
    send_item(OP_SCHED, 32'd1000,        24'd10,      8'd4);
    send_item(OP_SCHED, 32'd5000,        24'd5,       8'd5);  // head overdue, negative wait
    send_item(OP_POLL,  32'd1060,        24'd0,       8'd0);
    send_item(OP_POLL,  32'd4000,        24'd0,       8'd0);  // pause below the cap
    send_item(OP_POLL,  32'd5005,        24'd0,       8'd0);  // deadline equal to now fires

    // random part, one idling pattern and one default_wait per phase
    for (int p = 0; p < 4; p++) begin
      cap = (p == 3) ? 16'($urandom_range(65534, 2)) : phase_cap[p];
      write_cap(cap);
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      clock_ms  = $urandom_range(32'h7FFF_FFFF);
      if (p == 0) begin
        // receiver holds off while schedules keep coming: block backs up,
        // then the queue fills and the surplus schedules are turned away
        hold_asked++;
        run_burst(QUEUE_DEPTH_DEF + 2, 1'b0);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS)
        run_burst($urandom_range(20, 1), 1'b1);
    end

    s_tvalid <= 1'b0;
    wait_drained();

    $display("ran %0d input transactions over %0d default_wait settings and four idling phases",
             items_sent, cap_settings);
    $display("checked %0d results: %0d fired events, %0d schedules turned away on a full queue",
             results_checked, events_fired, schedules_rejected);
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
sv/dlq_pkg.sv
sv/dlq_ram.sv
sv/dlq_ctrl.sv
sv/deadline_event_queue.sv
sv/dlq_checker.sv
sim/dlq_result_check.sv
sim/tb_deadline_event_queue.sv
